@@ rtl/lcr_pkg.sv @@
// Shared types, widths and codes for the lifetime color ramp.
// Used by the channel interfaces, the controller, the datapath and the checker.
package lcr_pkg;

  localparam int MODE_W      = 2;
  localparam int ENTRY_W     = 3;
  localparam int POS_W       = 17;
  localparam int ALPHA_W     = 8;
  localparam int CHAN_W      = 16;
  localparam int RGB_W       = 3 * CHAN_W;
  localparam int TICK_W      = 32;
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 4;

  localparam int ALPHA_KEYS_DEF  = 8;
  localparam int COLOR_STEPS_DEF = 8;

  localparam int FRAC_STEPS  = 16;
  localparam int DIV_STEPS   = BYTE_W;
  localparam int SCALE_SHIFT = 16;
  localparam int SCALE_MUL_W = 8;

  localparam int ALPHA_ENTRY_W = POS_W + ALPHA_W;
  localparam int COLOR_ENTRY_W = POS_W + RGB_W;

  localparam int PROD_W = CHAN_W + POS_W;
  localparam int SUM_W  = PROD_W;
  localparam int DIV_W  = POS_W + DIV_STEPS;

  localparam logic [POS_W-1:0] ONE_Q16   = POS_W'(65536);
  localparam logic [POS_W-1:0] POS_UNIT  = POS_W'(1);

  typedef logic [CFG_DATA_W-1:0] count_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_ALPHA = 2'd0,
    MODE_LOAD_COLOR = 2'd1,
    MODE_EVAL       = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA_COUNT = 1'd0,
    CFG_COLOR_COUNT = 1'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CH_ALPHA = 2'd0,
    CH_RED   = 2'd1,
    CH_GREEN = 2'd2,
    CH_BLUE  = 2'd3
  } ch_t;

  typedef struct packed {
    logic frac_start;
    logic frac_step;
    logic rd_alpha;
    logic rd_color;
    logic rd_first;
    logic mul0;
    logic mul1;
    logic sum;
    logic scale;
    logic div_step;
    logic store;
    logic load_out;
    ch_t  ch;
  } dp_cmd_t;

  typedef struct packed {
    logic frac_sat;
  } dp_st_t;

endpackage

@@ rtl/lcr_if.sv @@
// Channel interfaces of the lifetime color ramp: input items, results, register writes.
// Depends on lcr_pkg.
interface lcr_in_if;
  import lcr_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [ENTRY_W-1:0]  entry_index;
  logic [POS_W-1:0]    key_position;
  logic [ALPHA_W-1:0]  key_alpha;
  logic [CHAN_W-1:0]   key_red;
  logic [CHAN_W-1:0]   key_green;
  logic [CHAN_W-1:0]   key_blue;
  logic [TICK_W-1:0]   age_ticks;
  logic [TICK_W-1:0]   lifetime_ticks;

  modport source (output valid, mode, entry_index, key_position, key_alpha, key_red,
                  key_green, key_blue, age_ticks, lifetime_ticks, input ready);
  modport sink   (input valid, mode, entry_index, key_position, key_alpha, key_red,
                  key_green, key_blue, age_ticks, lifetime_ticks, output ready);
endinterface

interface lcr_out_if;
  import lcr_pkg::*;
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_alpha;
  logic [BYTE_W-1:0]  out_red;
  logic [BYTE_W-1:0]  out_green;
  logic [BYTE_W-1:0]  out_blue;

  modport source (output valid, out_alpha, out_red, out_green, out_blue, input ready);
  modport sink   (input valid, out_alpha, out_red, out_green, out_blue, output ready);
endinterface

interface lcr_cfg_if;
  import lcr_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/lcr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/lcr_ctrl.sv @@
// Sequencing state machine of the lifetime color ramp: fraction, table walks,
// per-channel blend and output hand-off. Depends on lcr_pkg.
module lcr_ctrl #(
  parameter int ALPHA_KEYS  = lcr_pkg::ALPHA_KEYS_DEF,
  parameter int COLOR_STEPS = lcr_pkg::COLOR_STEPS_DEF,
  parameter int RD_IDX_W    = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  eval_go,
  input  lcr_pkg::count_t       alpha_cnt,
  input  lcr_pkg::count_t       color_cnt,
  input  logic                  out_ready,
  input  lcr_pkg::dp_st_t       st,
  output lcr_pkg::dp_cmd_t      cmd,
  output logic [RD_IDX_W-1:0]   rd_idx,
  output logic                  in_ready,
  output logic                  out_valid
);
  import lcr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FRAC, S_WALK_A, S_WALK_C, S_MUL0, S_MUL1, S_SUM, S_SCALE, S_DIV, S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [RD_IDX_W-1:0] cnt_r, cnt_nxt;
  ch_t                 ch_r, ch_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [RD_IDX_W-1:0] n_alpha, n_color;

  assign n_alpha = (RD_IDX_W'(alpha_cnt) > RD_IDX_W'(ALPHA_KEYS)) ?
                   RD_IDX_W'(ALPHA_KEYS) : RD_IDX_W'(alpha_cnt);
  assign n_color = (RD_IDX_W'(color_cnt) > RD_IDX_W'(COLOR_STEPS)) ?
                   RD_IDX_W'(COLOR_STEPS) : RD_IDX_W'(color_cnt);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ch_nxt        = ch_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.ch        = ch_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (eval_go) begin
          cmd.frac_start = 1'b1;
          cnt_nxt        = '0;
          state_nxt      = S_FRAC;
        end
      end
      S_FRAC: begin
        if (st.frac_sat) begin
          cnt_nxt   = '0;
          state_nxt = S_WALK_A;
        end else begin
          cmd.frac_step = 1'b1;
          if (cnt_r == RD_IDX_W'(FRAC_STEPS - 1)) begin
            cnt_nxt   = '0;
            state_nxt = S_WALK_A;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_WALK_A: begin
        if (cnt_r < n_alpha) begin
          cmd.rd_alpha = 1'b1;
          cmd.rd_first = (cnt_r == '0);
          cnt_nxt      = cnt_r + 1'b1;
        end else begin
          cnt_nxt   = '0;
          state_nxt = S_WALK_C;
        end
      end
      S_WALK_C: begin
        if (cnt_r < n_color) begin
          cmd.rd_color = 1'b1;
          cmd.rd_first = (cnt_r == '0);
          cnt_nxt      = cnt_r + 1'b1;
        end else begin
          cnt_nxt   = '0;
          ch_nxt    = CH_ALPHA;
          state_nxt = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd.mul0  = 1'b1;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == RD_IDX_W'(DIV_STEPS - 1)) begin
          cmd.store = 1'b1;
          cnt_nxt   = '0;
          case (ch_r)
            CH_ALPHA: begin
              ch_nxt    = CH_RED;
              state_nxt = S_MUL0;
            end
            CH_RED: begin
              ch_nxt    = CH_GREEN;
              state_nxt = S_MUL0;
            end
            CH_GREEN: begin
              ch_nxt    = CH_BLUE;
              state_nxt = S_MUL0;
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ch_r        <= CH_ALPHA;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign rd_idx    = cnt_r;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ rtl/lcr_dp.sv @@
// Datapath of the lifetime color ramp: serial life-fraction divider, segment match
// registers, shared multiplier, serial blend divider, result registers. Depends on lcr_pkg.
module lcr_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  lcr_pkg::dp_cmd_t                      cmd,
  output lcr_pkg::dp_st_t                       st,
  input  logic [lcr_pkg::TICK_W-1:0]            age_ticks,
  input  logic [lcr_pkg::TICK_W-1:0]            lifetime_ticks,
  input  logic [lcr_pkg::ALPHA_ENTRY_W-1:0]     a_rdata,
  input  logic [lcr_pkg::COLOR_ENTRY_W-1:0]     c_rdata,
  output logic [lcr_pkg::BYTE_W-1:0]            out_alpha,
  output logic [lcr_pkg::BYTE_W-1:0]            out_red,
  output logic [lcr_pkg::BYTE_W-1:0]            out_green,
  output logic [lcr_pkg::BYTE_W-1:0]            out_blue
);
  import lcr_pkg::*;

  logic [TICK_W-1:0]       life_r, frac_rem_r, frac_rem_nxt;
  logic [FRAC_STEPS-1:0]   fq_r;
  logic                    sat_r;
  logic [TICK_W:0]         frac_dbl;
  logic                    frac_ge;
  logic [POS_W-1:0]        f;

  logic                    a_vld_r, a_first_r, c_vld_r, c_first_r;
  logic [POS_W-1:0]        a_pos, a_prev_pos_r, a_wid, a_off;
  logic [ALPHA_W-1:0]      a_val, a_prev_val_r, a_v0_r, a_v1_r;
  logic [POS_W-1:0]        a_w_r, a_d_r;
  logic                    a_hit_r, a_in_seg;
  logic [POS_W-1:0]        c_pos, c_prev_pos_r, c_wid, c_off;
  logic [RGB_W-1:0]        c_rgb, c_prev_rgb_r, c_c0_r, c_c1_r;
  logic [POS_W-1:0]        c_w_r, c_d_r;
  logic                    c_hit_r, c_in_seg;

  logic [CHAN_W-1:0]       x0, x1, op_x;
  logic [POS_W-1:0]        sel_w, sel_d, op_y;
  logic                    sel_hit;
  logic [PROD_W-1:0]       prod_r;
  logic [SUM_W-1:0]        sum_r;
  logic [SUM_W+SCALE_MUL_W-1:0] x255;

  logic [DIV_W-1:0]        dv_rem_r, dsr_r, dv_rem_nxt;
  logic [BYTE_W-1:0]       q_r, q_nxt, q_res;
  logic                    dv_ge;
  logic [BYTE_W-1:0]       res_a_r, res_r_r, res_g_r, res_b_r;
  logic [BYTE_W-1:0]       out_a_r, out_r_r, out_g_r, out_b_r;

  // life fraction: restoring division of age * 2^16 by lifetime
  assign frac_dbl     = {frac_rem_r, 1'b0};
  assign frac_ge      = (frac_dbl >= {1'b0, life_r});
  assign frac_rem_nxt = frac_ge ? TICK_W'(frac_dbl - {1'b0, life_r}) : TICK_W'(frac_dbl);
  assign f            = sat_r ? ONE_Q16 : {1'b0, fq_r};
  assign st.frac_sat  = sat_r;

  always_ff @(posedge clk) begin
    if (cmd.frac_start) begin
      life_r     <= lifetime_ticks;
      frac_rem_r <= age_ticks;
      fq_r       <= '0;
      sat_r      <= (lifetime_ticks == '0) || (age_ticks >= lifetime_ticks);
    end else if (cmd.frac_step) begin
      frac_rem_r <= frac_rem_nxt;
      fq_r       <= {fq_r[FRAC_STEPS-2:0], frac_ge};
    end
  end

  // segment walk over registered table reads
  assign a_pos    = a_rdata[ALPHA_ENTRY_W-1 -: POS_W];
  assign a_val    = a_rdata[ALPHA_W-1:0];
  assign a_wid    = a_pos - a_prev_pos_r;
  assign a_off    = f - a_prev_pos_r;
  assign a_in_seg = a_vld_r && !a_first_r && (f >= a_prev_pos_r) && (f <= a_pos);

  assign c_pos    = c_rdata[COLOR_ENTRY_W-1 -: POS_W];
  assign c_rgb    = c_rdata[RGB_W-1:0];
  assign c_wid    = c_pos - c_prev_pos_r;
  assign c_off    = f - c_prev_pos_r;
  assign c_in_seg = c_vld_r && !c_first_r && (f >= c_prev_pos_r) && (f <= c_pos);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      a_hit_r <= 1'b0;
      c_hit_r <= 1'b0;
    end else begin
      a_vld_r <= cmd.rd_alpha;
      c_vld_r <= cmd.rd_color;
      if (cmd.frac_start) begin
        a_hit_r <= 1'b0;
        c_hit_r <= 1'b0;
      end else begin
        if (a_in_seg) begin
          a_hit_r <= 1'b1;
        end
        if (c_in_seg) begin
          c_hit_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    a_first_r <= cmd.rd_first;
    c_first_r <= cmd.rd_first;
    if (a_vld_r) begin
      a_prev_pos_r <= a_pos;
      a_prev_val_r <= a_val;
    end
    if (c_vld_r) begin
      c_prev_pos_r <= c_pos;
      c_prev_rgb_r <= c_rgb;
    end
    // zero-width segment: take the end value by blending with w = d = 1
    if (a_in_seg) begin
      a_w_r  <= (a_wid == '0) ? POS_UNIT : a_wid;
      a_d_r  <= (a_wid == '0) ? POS_UNIT : a_off;
      a_v0_r <= a_prev_val_r;
      a_v1_r <= a_val;
    end
    if (c_in_seg) begin
      c_w_r  <= (c_wid == '0) ? POS_UNIT : c_wid;
      c_d_r  <= (c_wid == '0) ? POS_UNIT : c_off;
      c_c0_r <= c_prev_rgb_r;
      c_c1_r <= c_rgb;
    end
  end

  // channel operand select
  always_comb begin
    x0      = CHAN_W'(a_v0_r);
    x1      = CHAN_W'(a_v1_r);
    sel_w   = a_w_r;
    sel_d   = a_d_r;
    sel_hit = a_hit_r;
    case (cmd.ch)
      CH_ALPHA: begin
        x0      = CHAN_W'(a_v0_r);
        x1      = CHAN_W'(a_v1_r);
        sel_w   = a_w_r;
        sel_d   = a_d_r;
        sel_hit = a_hit_r;
      end
      CH_RED: begin
        x0      = c_c0_r[3*CHAN_W-1 -: CHAN_W];
        x1      = c_c1_r[3*CHAN_W-1 -: CHAN_W];
        sel_w   = c_w_r;
        sel_d   = c_d_r;
        sel_hit = c_hit_r;
      end
      CH_GREEN: begin
        x0      = c_c0_r[2*CHAN_W-1 -: CHAN_W];
        x1      = c_c1_r[2*CHAN_W-1 -: CHAN_W];
        sel_w   = c_w_r;
        sel_d   = c_d_r;
        sel_hit = c_hit_r;
      end
      CH_BLUE: begin
        x0      = c_c0_r[CHAN_W-1:0];
        x1      = c_c1_r[CHAN_W-1:0];
        sel_w   = c_w_r;
        sel_d   = c_d_r;
        sel_hit = c_hit_r;
      end
      default: begin
        sel_hit = 1'b0;
      end
    endcase
  end

  assign op_x = cmd.mul0 ? x0 : x1;
  assign op_y = cmd.mul0 ? (sel_w - sel_d) : sel_d;
  assign x255 = {sum_r, {SCALE_MUL_W{1'b0}}} - (SUM_W + SCALE_MUL_W)'(sum_r);

  // serial blend divider, quotient below 2^DIV_STEPS
  assign dv_ge      = (dv_rem_r >= dsr_r);
  assign dv_rem_nxt = dv_ge ? (dv_rem_r - dsr_r) : dv_rem_r;
  assign q_nxt      = {q_r[BYTE_W-2:0], dv_ge};
  assign q_res      = sel_hit ? q_nxt : '0;

  always_ff @(posedge clk) begin
    if (cmd.mul0 || cmd.mul1) begin
      prod_r <= PROD_W'(op_x) * PROD_W'(op_y);
    end
    if (cmd.mul1) begin
      sum_r <= prod_r;
    end else if (cmd.sum) begin
      sum_r <= sum_r + prod_r;
    end
    if (cmd.scale) begin
      dv_rem_r <= (cmd.ch == CH_ALPHA) ? DIV_W'(sum_r) :
                  x255[SCALE_SHIFT +: DIV_W];
      dsr_r    <= DIV_W'({sel_w, {(DIV_STEPS-1){1'b0}}});
      q_r      <= '0;
    end else if (cmd.div_step) begin
      dv_rem_r <= dv_rem_nxt;
      dsr_r    <= dsr_r >> 1;
      q_r      <= q_nxt;
    end
    if (cmd.store) begin
      case (cmd.ch)
        CH_ALPHA: res_a_r <= q_res;
        CH_RED:   res_r_r <= q_res;
        CH_GREEN: res_g_r <= q_res;
        CH_BLUE:  res_b_r <= q_res;
        default:  res_a_r <= q_res;
      endcase
    end
    if (cmd.load_out) begin
      out_a_r <= res_a_r;
      out_r_r <= res_r_r;
      out_g_r <= res_g_r;
      out_b_r <= res_b_r;
    end
  end

  assign out_alpha = out_a_r;
  assign out_red   = out_r_r;
  assign out_green = out_g_r;
  assign out_blue  = out_b_r;

endmodule

@@ rtl/lifetime_color_ramp_core.sv @@
// Lifetime color ramp: alpha keypoint and color step tables with a serial evaluator.
// Depends on lcr_pkg, lcr_if, lcr_ram, lcr_ctrl and lcr_dp.
//
// Usage:
//   in_ch  carries load items (mode 0 alpha keypoint, mode 1 color step) and
//          evaluate items (mode 2). Loads write the table in the transaction cycle
//          and give no result; mode 3 is dropped.
//   out_ch carries one result (alpha, red, green, blue) per evaluate item.
//   cfg_ch writes the two entry counts; always ready. Write only while idle.
// Timing:
//   Loads may follow back to back; in_ch.ready stays high after a load.
//   An evaluate item holds in_ch.ready low while the radix-2 fraction divider
//   runs (16 steps, skipped when age >= lifetime or lifetime is 0), the alpha and
//   then the color table are walked over the entry counts in use, the four
//   channels are blended through one shared multiplier and an 8-step serial
//   divider, and the result is loaded into the output register.
//   Results sit in an output register: the next item is accepted while a result
//   waits, and a stalled result holds until taken. The next result waits for it.
// Reset: rst_n, synchronous; clears the counts and the control state. Table contents
//   are undefined until loaded.
module lifetime_color_ramp_core #(
  parameter int ALPHA_KEYS  = lcr_pkg::ALPHA_KEYS_DEF,
  parameter int COLOR_STEPS = lcr_pkg::COLOR_STEPS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  lcr_in_if.sink        in_ch,
  lcr_out_if.source     out_ch,
  lcr_cfg_if.sink       cfg_ch
);
  import lcr_pkg::*;

  localparam int AA_W      = $clog2(ALPHA_KEYS);
  localparam int CA_W      = $clog2(COLOR_STEPS);
  localparam int MAX_TAB   = (ALPHA_KEYS > COLOR_STEPS) ? ALPHA_KEYS : COLOR_STEPS;
  localparam int MAX_CNT   = (MAX_TAB > FRAC_STEPS) ? MAX_TAB : FRAC_STEPS;
  localparam int RD_IDX_W  = $clog2(MAX_CNT + 1);

  count_t               alpha_cnt_r, color_cnt_r;
  dp_cmd_t              cmd;
  dp_st_t               st;
  logic [RD_IDX_W-1:0]  rd_idx;
  logic                 in_ready, in_acc, eval_go, a_we, c_we;
  logic [ALPHA_ENTRY_W-1:0] a_rdata;
  logic [COLOR_ENTRY_W-1:0] c_rdata;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_cnt_r <= '0;
      color_cnt_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_ALPHA_COUNT: alpha_cnt_r <= cfg_ch.data;
        CFG_COLOR_COUNT: color_cnt_r <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = in_ready;
  assign in_acc      = in_ch.valid && in_ready;
  assign eval_go     = in_acc && (in_ch.mode == MODE_EVAL);
  assign a_we        = in_acc && (in_ch.mode == MODE_LOAD_ALPHA) &&
                       (32'(in_ch.entry_index) < ALPHA_KEYS);
  assign c_we        = in_acc && (in_ch.mode == MODE_LOAD_COLOR) &&
                       (32'(in_ch.entry_index) < COLOR_STEPS);

  lcr_ram #(
    .WIDTH (ALPHA_ENTRY_W),
    .DEPTH (ALPHA_KEYS)
  ) u_alpha_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (AA_W'(in_ch.entry_index)),
    .wdata ({in_ch.key_position, in_ch.key_alpha}),
    .raddr (rd_idx[AA_W-1:0]),
    .rdata (a_rdata)
  );

  lcr_ram #(
    .WIDTH (COLOR_ENTRY_W),
    .DEPTH (COLOR_STEPS)
  ) u_color_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (CA_W'(in_ch.entry_index)),
    .wdata ({in_ch.key_position, in_ch.key_red, in_ch.key_green, in_ch.key_blue}),
    .raddr (rd_idx[CA_W-1:0]),
    .rdata (c_rdata)
  );

  lcr_ctrl #(
    .ALPHA_KEYS  (ALPHA_KEYS),
    .COLOR_STEPS (COLOR_STEPS),
    .RD_IDX_W    (RD_IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .eval_go   (eval_go),
    .alpha_cnt (alpha_cnt_r),
    .color_cnt (color_cnt_r),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd),
    .rd_idx    (rd_idx),
    .in_ready  (in_ready),
    .out_valid (out_ch.valid)
  );

  lcr_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .age_ticks      (in_ch.age_ticks),
    .lifetime_ticks (in_ch.lifetime_ticks),
    .a_rdata        (a_rdata),
    .c_rdata        (c_rdata),
    .out_alpha      (out_ch.out_alpha),
    .out_red        (out_ch.out_red),
    .out_green      (out_ch.out_green),
    .out_blue       (out_ch.out_blue)
  );

endmodule

@@ rtl/lcr_checker.sv @@
// Port-level checks for lifetime_color_ramp_core, attached by bind.
// Depends on lcr_pkg.
module lcr_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [lcr_pkg::MODE_W-1:0] in_mode,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [lcr_pkg::BYTE_W-1:0] out_alpha,
  input logic [lcr_pkg::BYTE_W-1:0] out_red,
  input logic [lcr_pkg::BYTE_W-1:0] out_green,
  input logic [lcr_pkg::BYTE_W-1:0] out_blue
);
  import lcr_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_alpha) && $stable(out_red) &&
                                $stable(out_green) && $stable(out_blue))
    else $error("stalled result changed");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_mode == MODE_EVAL) |=> !in_ready && !$rose(out_valid))
    else $error("evaluate transaction did not occupy the block");

  a_load_stays_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_mode != MODE_EVAL) |=> in_ready)
    else $error("load transaction stalled the input");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_ready || $past(!in_ready))
    else $error("result appeared without an evaluation in progress");

endmodule

bind lifetime_color_ramp_core lcr_checker u_lcr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_mode   (in_ch.mode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_alpha (out_ch.out_alpha),
  .out_red   (out_ch.out_red),
  .out_green (out_ch.out_green),
  .out_blue  (out_ch.out_blue)
);
